@@ hdl/pgnv_pkg.sv @@
package pgnv_pkg;

  localparam int POS_W     = 24;
  localparam int LABEL_W   = 16;
  localparam int INDEX_W   = 15;
  localparam int COORD_W   = 6;   // grid side is at most 64
  localparam int RANK_W    = 3;
  localparam int RAD_W     = 3;
  localparam int CNT_W     = 4;
  localparam int OUT_CRD_W = 5;

  localparam logic [1:0] REG_BOX_LENGTH     = 2'd0;
  localparam logic [1:0] REG_SEARCH_RADIUS  = 2'd1;
  localparam logic [1:0] REG_NEIGHBOR_COUNT = 2'd2;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                         mode;
    logic [INDEX_W-1:0]           cell_index;
    logic [LABEL_W-1:0]           label;
    logic [2:0][POS_W-1:0]        pos;
    logic [2:0][COORD_W-1:0]      hcell;
  } job_t;

  typedef struct packed {
    logic [POS_W-1:0] len;
    logic [RAD_W-1:0] radius;
    logic [CNT_W-1:0] count;
  } cfg_t;

  typedef struct packed {
    logic [RANK_W-1:0]             rank;
    logic                          found;
    logic [POS_W-1:0]              dst;
    logic [LABEL_W-1:0]            label;
    logic [2:0][OUT_CRD_W-1:0]     crd;
    logic                          last;
  } res_t;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;

  typedef enum logic [4:0] {
    B_CLEAR, B_IDLE, B_ORG, B_PINIT, B_THR_A, B_THR_B, B_RD, B_CHK, B_DIF,
    B_IMG, B_SQ, B_SUM, B_SRCH_A, B_SRCH_B, B_SRCH_C, B_ADV, B_EMIT
  } back_state_t;

endpackage

@@ hdl/pgnv_fifo.sv @@
module pgnv_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  pgnv_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output pgnv_pkg::job_t dout,
  output logic          empty
);

  pgnv_pkg::job_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;

  assign full  = (cnt == 2'd2);
  assign empty = (cnt == 2'd0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ hdl/pgnv_front.sv @@
module pgnv_front #(
  parameter int GRID_SIZE = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pgnv_pkg::job_t                in_job,
  input  logic [pgnv_pkg::POS_W-1:0]    len,
  input  logic                          hold_off,
  output logic                          push,
  output pgnv_pkg::job_t                push_job,
  input  logic                          full
);

  localparam int DW  = pgnv_pkg::POS_W + $clog2(GRID_SIZE);
  localparam int STW = $clog2(DW);

  pgnv_pkg::front_state_t fst, fst_next;
  pgnv_pkg::job_t         hold;
  logic [DW-1:0]                dvd;
  logic [pgnv_pkg::POS_W-1:0]   rem;
  logic [STW-1:0]               step;
  logic [1:0]                   axis;
  logic                         phase;

  logic [pgnv_pkg::POS_W:0]     rem_s;
  logic [pgnv_pkg::POS_W:0]     rem_d;
  logic                         ge;
  logic [DW-1:0]                quo_n;
  logic                         div_end;
  logic                         accept;

  assign in_ready = (fst == pgnv_pkg::F_IDLE) && !hold_off;
  assign accept   = in_valid && in_ready;
  assign push     = (fst == pgnv_pkg::F_PUSH) && !full;
  assign push_job = hold;

  // one restoring division step a cycle
  always_comb begin
    rem_s   = {rem, dvd[DW-1]};
    ge      = rem_s >= {1'b0, len};
    rem_d   = ge ? rem_s - {1'b0, len} : rem_s;
    quo_n   = {dvd[DW-2:0], ge};
    div_end = (step == STW'(DW - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fst <= pgnv_pkg::F_IDLE;
    end else begin
      fst <= fst_next;
    end
  end

  always_comb begin
    fst_next = fst;
    unique case (fst)
      pgnv_pkg::F_IDLE: begin
        if (accept) begin
          fst_next = (in_job.mode == pgnv_pkg::MODE_QUERY) ? pgnv_pkg::F_DIV : pgnv_pkg::F_PUSH;
        end
      end
      pgnv_pkg::F_DIV: begin
        if (div_end && phase && axis == 2'd2) fst_next = pgnv_pkg::F_PUSH;
      end
      pgnv_pkg::F_PUSH: begin
        if (!full) fst_next = pgnv_pkg::F_IDLE;
      end
      default: fst_next = pgnv_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (fst)
      pgnv_pkg::F_IDLE: begin
        if (accept) begin
          hold  <= in_job;
          dvd   <= DW'(in_job.pos[0]);
          rem   <= '0;
          step  <= '0;
          axis  <= 2'd0;
          phase <= 1'b0;
        end
      end
      pgnv_pkg::F_DIV: begin
        if (!div_end) begin
          dvd  <= quo_n;
          rem  <= rem_d[pgnv_pkg::POS_W-1:0];
          step <= step + STW'(1);
        end else begin
          step <= '0;
          rem  <= '0;
          if (!phase) begin
            // position reduced modulo box length, then cell = pos*N / L
            hold.pos[axis] <= rem_d[pgnv_pkg::POS_W-1:0];
            dvd   <= DW'(rem_d[pgnv_pkg::POS_W-1:0]) * DW'(GRID_SIZE);
            phase <= 1'b1;
          end else begin
            hold.hcell[axis] <= pgnv_pkg::COORD_W'(quo_n);
            phase <= 1'b0;
            if (axis != 2'd2) begin
              axis <= axis + 2'd1;
              dvd  <= DW'(hold.pos[axis + 2'd1]);
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/pgnv_back.sv @@
module pgnv_back #(
  parameter int GRID_SIZE     = 32,
  parameter int MAX_NEIGHBORS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  pgnv_pkg::job_t job,
  input  logic           empty,
  output logic           pop,
  input  pgnv_pkg::cfg_t cfg,
  output logic           clearing,
  output pgnv_pkg::res_t res,
  output logic           res_valid,
  input  logic           res_ready
);

  localparam int CW    = $clog2(GRID_SIZE);
  localparam int CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int DWID  = pgnv_pkg::POS_W + CW + 1;
  localparam int SQW   = 2 * DWID;
  localparam int SUMW  = SQW + 2;
  localparam int BW    = $clog2(pgnv_pkg::POS_W);
  localparam int LW    = pgnv_pkg::LABEL_W;

  pgnv_pkg::back_state_t bst, bst_next;

  logic [LW-1:0]              mem [CELLS];
  logic [LW-1:0]              rd_data;
  logic [AW-1:0]              rd_addr;
  logic                       mem_we;
  logic [AW-1:0]              mem_wa;
  logic [LW-1:0]              mem_wd;
  logic [AW-1:0]              clr;

  logic [2:0][DWID-1:0]       bpos;
  logic [DWID-1:0]            nl2;
  logic [2:0][CW-1:0]         org;
  logic [2:0][CW-1:0]         crd;
  logic [2:0][3:0]            offs;
  logic [pgnv_pkg::RAD_W-1:0] k;
  logic [pgnv_pkg::RANK_W-1:0] pass;
  logic [pgnv_pkg::POS_W-1:0] best;
  logic [LW-1:0]              blabel;
  logic [2:0][CW-1:0]         bcrd;
  logic                       found;
  logic [pgnv_pkg::POS_W-1:0] sd;
  logic [BW-1:0]              bitn;
  logic [DWID-1:0]            t;
  logic [SQW-1:0]             tsq;
  logic [SQW-1:0]             thresh;
  logic [SUMW-1:0]            s_reg;
  logic [2:0][DWID-1:0]       am;
  logic [2:0][SQW-1:0]        sq;
  logic [LW-1:0]              cur_lab;
  logic                       thr_adv;
  logic [LW-1:0]              kept [MAX_NEIGHBORS];

  logic [3:0]                 span;
  logic                       seen;
  logic [SUMW-1:0]            s_sum;
  logic [pgnv_pkg::POS_W-1:0] cand;
  logic                       load_ok;
  logic                       emit_ok;
  logic                       last_pass;
  logic                       scan_done;

  function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0] c);
    wrap_inc = (c == CW'(GRID_SIZE - 1)) ? '0 : c + CW'(1);
  endfunction

  assign clearing = (bst == pgnv_pkg::B_CLEAR);
  assign pop      = (bst == pgnv_pkg::B_IDLE) && !empty;

  always_comb begin
    span    = {cfg.radius, 1'b0};
    rd_addr = AW'(crd[0]) + AW'(GRID_SIZE) * (AW'(crd[1]) + AW'(GRID_SIZE) * AW'(crd[2]));
    seen    = 1'b0;
    for (int q = 0; q < MAX_NEIGHBORS; q++) begin
      if (pgnv_pkg::RANK_W'(q) < pass && kept[q] == rd_data) seen = 1'b1;
    end
    s_sum     = SUMW'(sq[0]) + SUMW'(sq[1]) + SUMW'(sq[2]);
    cand      = sd | (pgnv_pkg::POS_W'(1) << bitn);
    load_ok   = {17'd0, job.cell_index} < 32'(CELLS);
    emit_ok   = !res_valid || res_ready;
    last_pass = (pgnv_pkg::CNT_W'(pass) == cfg.count - pgnv_pkg::CNT_W'(1));
    scan_done = (offs[0] == span) && (offs[1] == span) && (offs[2] == span);
    if (clearing) begin
      mem_we = 1'b1;
      mem_wa = clr;
      mem_wd = '0;
    end else begin
      mem_we = pop && (job.mode == pgnv_pkg::MODE_LOAD) && load_ok;
      mem_wa = AW'(job.cell_index);
      mem_wd = job.label;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bst <= pgnv_pkg::B_CLEAR;
    end else begin
      bst <= bst_next;
    end
  end

  always_comb begin
    bst_next = bst;
    unique case (bst)
      pgnv_pkg::B_CLEAR:  if (clr == AW'(CELLS - 1)) bst_next = pgnv_pkg::B_IDLE;
      pgnv_pkg::B_IDLE:   if (pop && job.mode == pgnv_pkg::MODE_QUERY) bst_next = pgnv_pkg::B_ORG;
      pgnv_pkg::B_ORG:    if (k == '0) bst_next = pgnv_pkg::B_PINIT;
      pgnv_pkg::B_PINIT:  bst_next = pgnv_pkg::B_THR_A;
      pgnv_pkg::B_THR_A:  bst_next = pgnv_pkg::B_THR_B;
      pgnv_pkg::B_THR_B:  bst_next = thr_adv ? pgnv_pkg::B_ADV : pgnv_pkg::B_RD;
      pgnv_pkg::B_RD:     bst_next = pgnv_pkg::B_CHK;
      pgnv_pkg::B_CHK:    bst_next = (rd_data == '0 || seen) ? pgnv_pkg::B_ADV : pgnv_pkg::B_DIF;
      pgnv_pkg::B_DIF:    bst_next = pgnv_pkg::B_IMG;
      pgnv_pkg::B_IMG:    bst_next = pgnv_pkg::B_SQ;
      pgnv_pkg::B_SQ:     bst_next = pgnv_pkg::B_SUM;
      pgnv_pkg::B_SUM:    bst_next = (s_sum < SUMW'(thresh)) ? pgnv_pkg::B_SRCH_A : pgnv_pkg::B_ADV;
      pgnv_pkg::B_SRCH_A: bst_next = pgnv_pkg::B_SRCH_B;
      pgnv_pkg::B_SRCH_B: bst_next = pgnv_pkg::B_SRCH_C;
      pgnv_pkg::B_SRCH_C: bst_next = (bitn == '0) ? pgnv_pkg::B_THR_A : pgnv_pkg::B_SRCH_A;
      pgnv_pkg::B_ADV:    bst_next = scan_done ? pgnv_pkg::B_EMIT : pgnv_pkg::B_RD;
      pgnv_pkg::B_EMIT: begin
        if (emit_ok) bst_next = last_pass ? pgnv_pkg::B_IDLE : pgnv_pkg::B_PINIT;
      end
      default: bst_next = pgnv_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      res_valid <= 1'b0;
    end else begin
      if (clearing) clr <= clr + AW'(1);
      if (bst == pgnv_pkg::B_EMIT && emit_ok) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (bst)
      pgnv_pkg::B_IDLE: begin
        if (pop && job.mode == pgnv_pkg::MODE_QUERY) begin
          for (int q = 0; q < 3; q++) begin
            bpos[q] <= DWID'(job.pos[q]) * DWID'(2 * GRID_SIZE);
            org[q]  <= CW'(job.hcell[q]);
          end
          nl2  <= DWID'(cfg.len) * DWID'(2 * GRID_SIZE);
          k    <= cfg.radius;
          pass <= '0;
        end
      end
      pgnv_pkg::B_ORG: begin
        // origin of the scan cube, wrapped down by the radius
        if (k != '0) begin
          for (int q = 0; q < 3; q++) begin
            org[q] <= (org[q] == '0) ? CW'(GRID_SIZE - 1) : org[q] - CW'(1);
          end
          k <= k - pgnv_pkg::RAD_W'(1);
        end
      end
      pgnv_pkg::B_PINIT: begin
        best    <= cfg.len;
        blabel  <= '0;
        bcrd    <= '0;
        found   <= 1'b0;
        sd      <= cfg.len;
        crd     <= org;
        offs    <= '0;
        thr_adv <= 1'b0;
      end
      pgnv_pkg::B_THR_A:  t <= DWID'(sd) * DWID'(2 * GRID_SIZE);
      pgnv_pkg::B_THR_B:  thresh <= SQW'(t) * SQW'(t);
      pgnv_pkg::B_CHK: begin
        cur_lab <= rd_data;
        for (int q = 0; q < 3; q++) begin
          am[q] <= DWID'(cfg.len) * DWID'({crd[q], 1'b1});
        end
      end
      pgnv_pkg::B_DIF: begin
        for (int q = 0; q < 3; q++) begin
          am[q] <= (am[q] > bpos[q]) ? am[q] - bpos[q] : bpos[q] - am[q];
        end
      end
      pgnv_pkg::B_IMG: begin
        // minimum image
        for (int q = 0; q < 3; q++) begin
          if (am[q] >= {1'b0, nl2[DWID-1:1]}) am[q] <= nl2 - am[q];
        end
      end
      pgnv_pkg::B_SQ: begin
        for (int q = 0; q < 3; q++) begin
          sq[q] <= SQW'(am[q]) * SQW'(am[q]);
        end
      end
      pgnv_pkg::B_SUM: begin
        if (s_sum < SUMW'(thresh)) begin
          blabel <= cur_lab;
          bcrd   <= crd;
          found  <= 1'b1;
          s_reg  <= s_sum;
          sd     <= '0;
          bitn   <= BW'(pgnv_pkg::POS_W - 1);
        end
      end
      pgnv_pkg::B_SRCH_A: t <= DWID'(cand) * DWID'(2 * GRID_SIZE);
      pgnv_pkg::B_SRCH_B: tsq <= SQW'(t) * SQW'(t);
      pgnv_pkg::B_SRCH_C: begin
        if (SUMW'(tsq) <= s_reg) sd <= cand;
        if (bitn == '0) begin
          best    <= (SUMW'(tsq) <= s_reg) ? cand : sd;
          thr_adv <= 1'b1;
        end else begin
          bitn <= bitn - BW'(1);
        end
      end
      pgnv_pkg::B_ADV: begin
        thr_adv <= 1'b0;
        if (offs[2] != span) begin
          offs[2] <= offs[2] + 4'd1;
          crd[2]  <= wrap_inc(crd[2]);
        end else begin
          offs[2] <= '0;
          crd[2]  <= org[2];
          if (offs[1] != span) begin
            offs[1] <= offs[1] + 4'd1;
            crd[1]  <= wrap_inc(crd[1]);
          end else begin
            offs[1] <= '0;
            crd[1]  <= org[1];
            if (offs[0] != span) begin
              offs[0] <= offs[0] + 4'd1;
              crd[0]  <= wrap_inc(crd[0]);
            end
          end
        end
      end
      pgnv_pkg::B_EMIT: begin
        if (emit_ok) begin
          res.rank  <= pass;
          res.found <= found;
          res.dst   <= best;
          res.label <= blabel;
          for (int q = 0; q < 3; q++) begin
            res.crd[q] <= pgnv_pkg::OUT_CRD_W'(bcrd[q]);
          end
          res.last <= last_pass;
          for (int q = 0; q < MAX_NEIGHBORS; q++) begin
            if (pgnv_pkg::RANK_W'(q) == pass) kept[q] <= blabel;
          end
          pass <= pass + pgnv_pkg::RANK_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/periodic_grid_nearest_void_regions.sv @@
// Load item: accepted by the front, queued, then written to the grid when the back end
// pops it; no result. Query: the front divides each axis position twice (one divider
// bit a cycle), the back places the scan origin by the radius R, then each pass scans
// the (2R+1)^3 cells (one label read per cell) and refines the distance for each nearer cell.
// Items are handled one at a time through the back end; a 2-item queue decouples.
// After reset the grid is cleared, during which no item is taken.
module periodic_grid_nearest_void_regions #(
  parameter int GRID_SIZE     = 32,
  parameter int MAX_NEIGHBORS = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // cell_index, region_label, pos_x, pos_y, pos_z
  input  logic         s_tuser,   // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,   // rank, dist_res, found_label, void_x, void_y, void_z
  output logic         m_tuser,   // found
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data
);

  logic [pgnv_pkg::POS_W-1:0] box_length;
  logic [pgnv_pkg::RAD_W-1:0] search_radius;
  logic [pgnv_pkg::CNT_W-1:0] neighbor_count;

  pgnv_pkg::cfg_t cfg;
  pgnv_pkg::job_t in_job;
  pgnv_pkg::job_t push_job;
  pgnv_pkg::job_t pop_job;
  pgnv_pkg::res_t res;
  logic push, full, pop, empty, clearing;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_length     <= 24'hFFFFFF;
      search_radius  <= 3'd1;
      neighbor_count <= 4'd3;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        pgnv_pkg::REG_BOX_LENGTH:     box_length     <= cfg_data;
        pgnv_pkg::REG_SEARCH_RADIUS:  search_radius  <= cfg_data[pgnv_pkg::RAD_W-1:0];
        pgnv_pkg::REG_NEIGHBOR_COUNT: neighbor_count <= cfg_data[pgnv_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cfg.len    = (box_length == '0) ? pgnv_pkg::POS_W'(1) : box_length;
    cfg.radius = search_radius;
    if (neighbor_count == '0) begin
      cfg.count = pgnv_pkg::CNT_W'(1);
    end else if (neighbor_count > pgnv_pkg::CNT_W'(MAX_NEIGHBORS)) begin
      cfg.count = pgnv_pkg::CNT_W'(MAX_NEIGHBORS);
    end else begin
      cfg.count = neighbor_count;
    end
    in_job.mode       = s_tuser;
    in_job.cell_index = s_tdata[14:0];
    in_job.label      = s_tdata[30:15];
    in_job.pos[0]     = s_tdata[54:31];
    in_job.pos[1]     = s_tdata[78:55];
    in_job.pos[2]     = s_tdata[102:79];
    in_job.hcell      = '0;
  end

  pgnv_front #(.GRID_SIZE(GRID_SIZE)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_job   (in_job),
    .len      (cfg.len),
    .hold_off (clearing),
    .push     (push),
    .push_job (push_job),
    .full     (full)
  );

  pgnv_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_job),
    .full  (full),
    .pop   (pop),
    .dout  (pop_job),
    .empty (empty)
  );

  pgnv_back #(.GRID_SIZE(GRID_SIZE), .MAX_NEIGHBORS(MAX_NEIGHBORS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (pop_job),
    .empty     (empty),
    .pop       (pop),
    .cfg       (cfg),
    .clearing  (clearing),
    .res       (res),
    .res_valid (m_tvalid),
    .res_ready (m_tready)
  );

  assign m_tdata = {6'd0, res.crd[2], res.crd[1], res.crd[0], res.label, res.dst, res.rank};
  assign m_tuser = res.found;
  assign m_tlast = res.last;

endmodule
